/* sv/rpf_pkg.sv */
// ----------------------------------------------------------------------------
// rpf_pkg
// Types and constants shared by the receive filter, its cells and channels.
// ----------------------------------------------------------------------------
package rpf_pkg;

   localparam int unsigned HDR_BYTES = 8;
   localparam logic [8:0]  COUNT_MAX = 9'd511;

   // header byte positions
   localparam logic [2:0] POS_MAGIC  = 3'd0;
   localparam logic [2:0] POS_ID     = 3'd1;
   localparam logic [2:0] POS_SUM_LO = 3'd2;
   localparam logic [2:0] POS_SUM_HI = 3'd3;
   localparam logic [2:0] POS_TYPE   = 3'd4;
   localparam logic [2:0] POS_SRC    = 3'd5;
   localparam logic [2:0] POS_DEST   = 3'd6;
   localparam logic [2:0] POS_LENGTH = 3'd7;

   // verdict codes
   localparam logic [3:0] VERDICT_SHORT     = 4'd0;
   localparam logic [3:0] VERDICT_BAD_MAGIC = 4'd1;
   localparam logic [3:0] VERDICT_BAD_SUM   = 4'd2;
   localparam logic [3:0] VERDICT_TRUNC     = 4'd3;
   localparam logic [3:0] VERDICT_ACK       = 4'd4;
   localparam logic [3:0] VERDICT_ANNOUNCE  = 4'd5;
   localparam logic [3:0] VERDICT_NEW       = 4'd6;
   localparam logic [3:0] VERDICT_DUP       = 4'd7;
   localparam logic [3:0] VERDICT_NOT_MINE  = 4'd8;
   localparam logic [3:0] VERDICT_UNKNOWN   = 4'd9;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [2:0] CSR_MAGIC     = 3'd0;
   localparam logic [2:0] CSR_NODE_ID   = 3'd1;
   localparam logic [2:0] CSR_BROADCAST = 3'd2;
   localparam logic [2:0] CSR_CODE_ACK  = 3'd3;
   localparam logic [2:0] CSR_CODE_ANN  = 3'd4;
   localparam logic [2:0] CSR_CODE_SGL  = 3'd5;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] verdict;
      logic [7:0] packet_type;
      logic [7:0] source;
      logic [7:0] destination;
      logic [7:0] packet_id;
      logic [7:0] payload_length;
      logic       ack_due;
   } rsp_payload_type;

   // one entry of the recent-id chain, handed from cell to cell
   typedef struct packed {
      logic       valid;
      logic [7:0] id;
   } entry_type;

endpackage

/* sv/rpf_channels.sv */
// ----------------------------------------------------------------------------
// rpf_channels
// Valid/ready channels carrying received bytes and packet verdicts.
// ----------------------------------------------------------------------------
interface rpf_req_if;
   logic                    valid;
   logic                    ready;
   rpf_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rpf_rsp_if;
   logic                    valid;
   logic                    ready;
   rpf_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/radio_packet_rx_filter_core.sv */
// ----------------------------------------------------------------------------
// radio_packet_rx_filter_core
// The verdict is registered: it is valid in the cycle after the last byte is taken.
// Throughput: one byte per cycle while no verdict waits untaken; a waiting verdict holds off input beats until taken.
// Reset (synchronous) clears packet state, empties the id chain, loads defaults.
// ----------------------------------------------------------------------------
module radio_packet_rx_filter_core #(
   parameter int unsigned DEDUP_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   rpf_req_if.sink                          req_chan,
   rpf_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [rpf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_wdata
);
   import rpf_pkg::*;

   // configuration
   logic [7:0] magic_value_ff, my_node_id_ff, broadcast_addr_ff;
   logic [7:0] code_ack_ff, code_announce_ff, code_single_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_value_ff    <= 8'd0;
         my_node_id_ff     <= 8'd0;
         broadcast_addr_ff <= 8'd255;
         code_ack_ff       <= 8'd2;
         code_announce_ff  <= 8'd1;
         code_single_ff    <= 8'd3;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAGIC:     magic_value_ff    <= csr_wdata;
            CSR_NODE_ID:   my_node_id_ff     <= csr_wdata;
            CSR_BROADCAST: broadcast_addr_ff <= csr_wdata;
            CSR_CODE_ACK:  code_ack_ff       <= csr_wdata;
            CSR_CODE_ANN:  code_announce_ff  <= csr_wdata;
            CSR_CODE_SGL:  code_single_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // packet state
   logic [8:0]  count_ff, count_in;
   logic [7:0]  hdr_magic_ff, hdr_magic_in;
   logic [7:0]  hdr_id_ff, hdr_id_in;
   logic [15:0] hdr_sum_ff, hdr_sum_in;
   logic [7:0]  hdr_type_ff, hdr_type_in;
   logic [7:0]  hdr_source_ff, hdr_source_in;
   logic [7:0]  hdr_dest_ff, hdr_dest_in;
   logic [7:0]  hdr_length_ff, hdr_length_in;
   logic [15:0] sum_ff, sum_in;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       accept;
   logic [7:0] rx_byte;
   logic       last_byte;
   logic       in_header;
   logic [2:0] pos;
   logic [8:0] pay_idx;
   logic       add_byte;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx_byte        = req_chan.payload.rx_byte;
   assign last_byte      = req_chan.payload.last_byte;

   assign in_header = (count_ff < 9'(HDR_BYTES));
   assign pos       = count_ff[2:0];
   assign pay_idx   = count_ff - 9'(HDR_BYTES);

   always_comb begin
      hdr_magic_in  = hdr_magic_ff;
      hdr_id_in     = hdr_id_ff;
      hdr_sum_in    = hdr_sum_ff;
      hdr_type_in   = hdr_type_ff;
      hdr_source_in = hdr_source_ff;
      hdr_dest_in   = hdr_dest_ff;
      hdr_length_in = hdr_length_ff;
      add_byte      = 1'b0;
      if (in_header) begin
         add_byte = (pos != POS_SUM_LO) && (pos != POS_SUM_HI);
         case (pos)
            POS_MAGIC:  hdr_magic_in     = rx_byte;
            POS_ID:     hdr_id_in        = rx_byte;
            POS_SUM_LO: hdr_sum_in[7:0]  = rx_byte;
            POS_SUM_HI: hdr_sum_in[15:8] = rx_byte;
            POS_TYPE:   hdr_type_in      = rx_byte;
            POS_SRC:    hdr_source_in    = rx_byte;
            POS_DEST:   hdr_dest_in      = rx_byte;
            POS_LENGTH: hdr_length_in    = rx_byte;
            default: ;
         endcase
      end else begin
         // bytes past the declared length are taken but not summed
         add_byte = (pay_idx < {1'b0, hdr_length_ff});
      end
      sum_in   = add_byte ? (sum_ff + {8'd0, rx_byte}) : sum_ff;
      count_in = (count_ff != COUNT_MAX) ? (count_ff + 9'd1) : count_ff;
   end

   // recent-id chain
   entry_type               chain [DEDUP_DEPTH+1];
   logic [DEDUP_DEPTH-1:0]  hit;
   logic                    insert;

   assign chain[0].valid = 1'b1;
   assign chain[0].id    = hdr_id_ff;

   for (genvar g = 0; g < DEDUP_DEPTH; g++) begin : g_cell
      rpf_dedup_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (insert),
         .entry_in  (chain[g]),
         .cmp_id    (hdr_id_ff),
         .entry_out (chain[g+1]),
         .match     (hit[g])
      );
   end

   // verdict
   logic       is_short, for_me;
   logic [8:0] payload_rx;

   assign is_short   = (count_in < 9'(HDR_BYTES));
   assign payload_rx = count_in - 9'(HDR_BYTES);
   assign for_me     = (hdr_dest_in == broadcast_addr_ff) || (hdr_dest_in == my_node_id_ff);

   always_comb begin
      rsp_payload_in.verdict        = VERDICT_UNKNOWN;
      rsp_payload_in.packet_type    = hdr_type_in;
      rsp_payload_in.source         = hdr_source_in;
      rsp_payload_in.destination    = hdr_dest_in;
      rsp_payload_in.packet_id      = hdr_id_in;
      rsp_payload_in.payload_length = hdr_length_in;
      rsp_payload_in.ack_due        = 1'b0;
      insert                        = 1'b0;
      if (is_short) begin
         rsp_payload_in         = '0;
         rsp_payload_in.verdict = VERDICT_SHORT;
      end else if (hdr_magic_in != magic_value_ff) begin
         rsp_payload_in.verdict = VERDICT_BAD_MAGIC;
      end else if ({1'b0, hdr_length_in} > payload_rx) begin
         rsp_payload_in.verdict = VERDICT_TRUNC;
      end else if (sum_in != hdr_sum_in) begin
         rsp_payload_in.verdict = VERDICT_BAD_SUM;
      end else if (hdr_type_in == code_ack_ff) begin
         rsp_payload_in.verdict = VERDICT_ACK;
      end else if (hdr_type_in == code_announce_ff) begin
         rsp_payload_in.verdict = VERDICT_ANNOUNCE;
      end else if (hdr_type_in == code_single_ff) begin
         if (for_me) begin
            rsp_payload_in.ack_due = 1'b1;
            if (|hit) begin
               rsp_payload_in.verdict = VERDICT_DUP;
            end else begin
               rsp_payload_in.verdict = VERDICT_NEW;
               insert                 = accept && last_byte;
            end
         end else begin
            rsp_payload_in.verdict = VERDICT_NOT_MINE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         hdr_magic_ff  <= '0;
         hdr_id_ff     <= '0;
         hdr_sum_ff    <= '0;
         hdr_type_ff   <= '0;
         hdr_source_ff <= '0;
         hdr_dest_ff   <= '0;
         hdr_length_ff <= '0;
         sum_ff        <= '0;
      end else if (accept) begin
         if (last_byte) begin
            // drop packet state, ready for the next header
            count_ff      <= '0;
            hdr_magic_ff  <= '0;
            hdr_id_ff     <= '0;
            hdr_sum_ff    <= '0;
            hdr_type_ff   <= '0;
            hdr_source_ff <= '0;
            hdr_dest_ff   <= '0;
            hdr_length_ff <= '0;
            sum_ff        <= '0;
         end else begin
            count_ff      <= count_in;
            hdr_magic_ff  <= hdr_magic_in;
            hdr_id_ff     <= hdr_id_in;
            hdr_sum_ff    <= hdr_sum_in;
            hdr_type_ff   <= hdr_type_in;
            hdr_source_ff <= hdr_source_in;
            hdr_dest_ff   <= hdr_dest_in;
            hdr_length_ff <= hdr_length_in;
            sum_ff        <= sum_in;
         end
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_byte) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

/* sv/rpf_dedup_cell.sv */
// ----------------------------------------------------------------------------
// rpf_dedup_cell
// One slot of the recent-id chain: holds an id, shifts it on, flags a match.
// ----------------------------------------------------------------------------
module rpf_dedup_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  rpf_pkg::entry_type entry_in,
   input  logic [7:0]         cmp_id,
   output rpf_pkg::entry_type entry_out,
   output logic               match
);
   import rpf_pkg::*;

   logic       valid_ff;
   logic [7:0] id_ff;
   logic       match_ff;
   logic       match_in;

   assign match_in = valid_ff && (id_ff == cmp_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
         if (shift_en) begin
            valid_ff <= entry_in.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         id_ff <= entry_in.id;
      end
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.id    = id_ff;
   assign match           = match_ff;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the radio packet receive filter. Streams whole,
// damaged and noise packets through the byte channel, works out each verdict
// in step with the accepted beats and checks it against the result channel,
// over several register settings and flow-control patterns.
// ----------------------------------------------------------------------------
module testbench;
   import rpf_pkg::*;

   localparam int unsigned RING_DEPTH = 16;
   localparam int unsigned ID_POOL    = 24;
   localparam int unsigned LONG_HOLD  = 300;
   localparam int unsigned SETTLE     = 4;

   // indexes past the register list; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata = '0;

   rpf_req_if req_if ();
   rpf_rsp_if rsp_if ();

   radio_packet_rx_filter_core #(
      .DEDUP_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // filter settings as last written
   logic [7:0] cfg_magic, cfg_node, cfg_bcast, cfg_ack, cfg_announce, cfg_single;

   // packet being parsed
   logic [8:0]  rx_count;
   logic [7:0]  hdr_magic, hdr_id, hdr_type, hdr_src, hdr_dst, hdr_len;
   logic [15:0] hdr_sum, sum_acc;

   // ring of recently accepted single-packet ids
   logic [7:0]                    ring_id [RING_DEPTH];
   logic [RING_DEPTH-1:0]         ring_valid;
   logic [$clog2(RING_DEPTH)-1:0] ring_wr;

   req_payload_type beats_pending [$];
   rsp_payload_type verdicts_due [$];
   rsp_payload_type verdict_want;

   int unsigned beats_queued = 0;
   int unsigned beats_offered = 0;
   int unsigned beats_taken = 0;
   int unsigned packets_queued = 0;
   int unsigned settings_used = 1;
   int unsigned errors = 0;
   int unsigned verdict_tally [10];

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_left = 0;

   task automatic clear_packet();
      rx_count  = '0;
      hdr_magic = '0;
      hdr_id    = '0;
      hdr_sum   = '0;
      hdr_type  = '0;
      hdr_src   = '0;
      hdr_dst   = '0;
      hdr_len   = '0;
      sum_acc   = '0;
   endtask

   // Fold one accepted byte into the packet state; on the last byte queue
   // the verdict it must produce.
   task automatic judge_beat(input req_payload_type beat);
      rsp_payload_type v;
      logic            hit;
      if (rx_count < HDR_BYTES) begin
         case (rx_count[2:0])
            POS_MAGIC:  hdr_magic = beat.rx_byte;
            POS_ID:     hdr_id = beat.rx_byte;
            POS_SUM_LO: hdr_sum[7:0] = beat.rx_byte;
            POS_SUM_HI: hdr_sum[15:8] = beat.rx_byte;
            POS_TYPE:   hdr_type = beat.rx_byte;
            POS_SRC:    hdr_src = beat.rx_byte;
            POS_DEST:   hdr_dst = beat.rx_byte;
            default:    hdr_len = beat.rx_byte;
         endcase
         if (rx_count[2:0] != POS_SUM_LO && rx_count[2:0] != POS_SUM_HI)
            sum_acc = sum_acc + beat.rx_byte;
      end else if (rx_count - HDR_BYTES < hdr_len) begin
         sum_acc = sum_acc + beat.rx_byte;
      end
      if (rx_count != COUNT_MAX)
         rx_count = rx_count + 9'd1;
      if (!beat.last_byte)
         return;

      v = '0;
      if (rx_count < HDR_BYTES) begin
         v.verdict = VERDICT_SHORT;
      end else begin
         v.packet_type    = hdr_type;
         v.source         = hdr_src;
         v.destination    = hdr_dst;
         v.packet_id      = hdr_id;
         v.payload_length = hdr_len;
         if (hdr_magic != cfg_magic) begin
            v.verdict = VERDICT_BAD_MAGIC;
         end else if (hdr_len > rx_count - HDR_BYTES) begin
            v.verdict = VERDICT_TRUNC;
         end else if (sum_acc != hdr_sum) begin
            v.verdict = VERDICT_BAD_SUM;
         end else if (hdr_type == cfg_ack) begin
            v.verdict = VERDICT_ACK;
         end else if (hdr_type == cfg_announce) begin
            v.verdict = VERDICT_ANNOUNCE;
         end else if (hdr_type == cfg_single) begin
            if (hdr_dst == cfg_bcast || hdr_dst == cfg_node) begin
               v.ack_due = 1'b1;
               hit = 1'b0;
               for (int i = 0; i < RING_DEPTH; i++)
                  if (ring_valid[i] && ring_id[i] == hdr_id)
                     hit = 1'b1;
               if (hit) begin
                  v.verdict = VERDICT_DUP;
               end else begin
                  v.verdict = VERDICT_NEW;
                  ring_id[ring_wr]    = hdr_id;
                  ring_valid[ring_wr] = 1'b1;
                  ring_wr             = ring_wr + 1'b1;
               end
            end else begin
               v.verdict = VERDICT_NOT_MINE;
            end
         end else begin
            v.verdict = VERDICT_UNKNOWN;
         end
      end
      verdicts_due.insert(verdicts_due.size(), v);
      clear_packet();
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Sample everything at the rising edge: register writes, byte beats and
   // verdict beats.
   always @(posedge clock) begin
      if (reset) begin
         cfg_magic    = 8'd0;
         cfg_node     = 8'd0;
         cfg_bcast    = 8'd255;
         cfg_ack      = 8'd2;
         cfg_announce = 8'd1;
         cfg_single   = 8'd3;
         clear_packet();
         ring_valid   = '0;
         ring_wr      = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAGIC:     cfg_magic = csr_wdata;
               CSR_NODE_ID:   cfg_node = csr_wdata;
               CSR_BROADCAST: cfg_bcast = csr_wdata;
               CSR_CODE_ACK:  cfg_ack = csr_wdata;
               CSR_CODE_ANN:  cfg_announce = csr_wdata;
               CSR_CODE_SGL:  cfg_single = csr_wdata;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            judge_beat(req_if.payload);
            beats_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (rsp_if.payload.verdict <= VERDICT_UNKNOWN)
               verdict_tally[rsp_if.payload.verdict]++;
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected verdict beat, expected none, actual verdict %0d",
                        $time, rsp_if.payload.verdict);
               errors++;
            end else begin
               verdict_want = verdicts_due[0];
               verdicts_due.delete(0);
               check_field("verdict", verdict_want.verdict, rsp_if.payload.verdict);
               check_field("packet_type", verdict_want.packet_type,
                           rsp_if.payload.packet_type);
               check_field("source", verdict_want.source, rsp_if.payload.source);
               check_field("destination", verdict_want.destination,
                           rsp_if.payload.destination);
               check_field("packet_id", verdict_want.packet_id, rsp_if.payload.packet_id);
               check_field("payload_length", verdict_want.payload_length,
                           rsp_if.payload.payload_length);
               check_field("ack_due", verdict_want.ack_due, rsp_if.payload.ack_due);
            end
         end
      end
   end

   // Byte driver: hold the current beat until taken, then maybe offer the next.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (beats_taken == beats_offered) begin
         if (beats_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_if.payload <= beats_pending[0];
            beats_pending.delete(0);
            req_if.valid   <= 1'b1;
            beats_offered++;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Verdict receiver with random stalls and an occasional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic push_beat(input logic [7:0] value, input logic last);
      req_payload_type beat;
      beat.rx_byte   = value;
      beat.last_byte = last;
      beats_pending.insert(beats_pending.size(), beat);
      beats_queued++;
      if (last)
         packets_queued++;
   endtask

   task automatic queue_noise(input int unsigned count);
      for (int unsigned k = 0; k < count; k++)
         push_beat(8'($urandom), k == count - 1);
   endtask

   // Header plus body_len payload bytes; the checksum covers the header fields and the
   // first len payload bytes, and is then xored with sum_flip.
   task automatic queue_frame(input logic [7:0] magic, id, ptype, src, dst, len,
                              input int unsigned body_len, input logic [15:0] sum_flip);
      logic [7:0]  body [$];
      logic [15:0] sum;
      sum = magic + id + ptype + src + dst + len;
      for (int unsigned k = 0; k < body_len; k++) begin
         body.insert(body.size(), 8'($urandom));
         if (k < len)
            sum = sum + body[k];
      end
      sum = sum ^ sum_flip;
      push_beat(magic, 1'b0);
      push_beat(id, 1'b0);
      push_beat(sum[7:0], 1'b0);
      push_beat(sum[15:8], 1'b0);
      push_beat(ptype, 1'b0);
      push_beat(src, 1'b0);
      push_beat(dst, 1'b0);
      push_beat(len, body_len == 0);
      for (int unsigned k = 0; k < body_len; k++)
         push_beat(body[k], k == body_len - 1);
   endtask

   task automatic queue_random_packet();
      int unsigned roll;
      int unsigned extra;
      logic [7:0]  id, ptype, dst, len;
      roll = $urandom_range(99);
      id = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(ID_POOL - 1));
      case ($urandom_range(9))
         0, 1:       ptype = cfg_ack;
         2:          ptype = cfg_announce;
         3, 4, 5, 6: ptype = cfg_single;
         default:    ptype = 8'($urandom);
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3: dst = cfg_node;
         4, 5, 6:    dst = cfg_bcast;
         default:    dst = 8'($urandom);
      endcase
      len = ($urandom_range(19) == 0) ? 8'($urandom_range(7, 40)) : 8'($urandom_range(6));
      extra = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
      if (roll < 64) begin
         queue_frame(cfg_magic, id, ptype, 8'($urandom), dst, len, len + extra, 16'h0);
      end else if (roll < 72) begin
         queue_frame(cfg_magic ^ 8'($urandom_range(1, 255)), id, ptype, 8'($urandom), dst,
                     len, len + extra, 16'h0);
      end else if (roll < 80) begin
         queue_frame(cfg_magic, id, ptype, 8'($urandom), dst, len, len + extra,
                     16'($urandom_range(1, 65535)));
      end else if (roll < 88) begin
         len = 8'($urandom_range(1, 12));
         queue_frame(cfg_magic, id, ptype, 8'($urandom), dst, len,
                     $urandom_range(0, len - 1), 16'h0);
      end else if (roll < 94) begin
         queue_noise($urandom_range(1, 7));
      end else begin
         queue_noise($urandom_range(8, 20));
      end
   endtask

   // Wait for every beat to be taken and every verdict to arrive, then let
   // the pipeline settle.
   task automatic drain();
      while (!(beats_pending.size() == 0 && beats_taken == beats_offered &&
               verdicts_due.size() == 0))
         @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   task automatic program_filter(input logic [7:0] magic, node, bcast, ack, ann, sgl);
      write_reg(CSR_MAGIC, magic);
      write_reg(CSR_NODE_ID, node);
      write_reg(CSR_BROADCAST, bcast);
      write_reg(CSR_CODE_ACK, ack);
      write_reg(CSR_CODE_ANN, ann);
      write_reg(CSR_CODE_SGL, sgl);
      write_reg(CSR_SPARE_LO, 8'($urandom));
      write_reg(CSR_SPARE_HI, 8'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int unsigned idle_pct, stall_pct, budget,
                            input bit pauses, input bit long_hold);
      int unsigned start;
      int unsigned count;
      start = beats_queued;
      count = 0;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      while (beats_queued - start < budget) begin
         queue_random_packet();
         count++;
         // pause the sender until the block is empty
         if (pauses && count % 20 == 0)
            drain();
         if (long_hold && count == 4) begin
            @(posedge clock);
            hold_left = LONG_HOLD;
         end
      end
      drain();
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      foreach (verdict_tally[i])
         verdict_tally[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: short packets, then a broadcast single sent twice
      push_beat(8'hFF, 1'b1);
      for (int k = 0; k < 7; k++)
         push_beat(k[0] ? 8'hFF : 8'h00, k == 6);
      repeat (2)
         queue_frame(cfg_magic, 8'hFF, cfg_single, 8'hFF, cfg_bcast, 8'h00, 0, 16'h0);
      drain();
      // saturate the byte counter with one oversized packet
      queue_frame(cfg_magic, 8'd200, cfg_single, 8'h11, cfg_bcast, 8'hFF, 515, 16'h0);
      run_phase(0, 0, 230, 1'b0, 1'b1);

      program_filter(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01);
      run_phase(81, 0, 230, 1'b0, 1'b0);

      // colliding type codes, node address equal to broadcast
      begin
         logic [7:0] code, addr;
         code = 8'($urandom);
         addr = 8'($urandom);
         program_filter(8'($urandom), addr, addr, code, code, code);
      end
      run_phase(0, 81, 230, 1'b0, 1'b1);

      program_filter(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      run_phase(38, 38, 230, 1'b1, 1'b0);

      program_filter(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h7F);
      run_phase(0, 0, 230, 1'b0, 1'b0);

      program_filter(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      run_phase(0, 81, 230, 1'b0, 1'b0);

      repeat (20) @(posedge clock);
      $display("Streamed %0d bytes in %0d packets under %0d filter settings, with hold-offs",
               beats_queued, packets_queued, settings_used);
      $display("Verdicts short..unknown: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
               verdict_tally[4], verdict_tally[5], verdict_tally[6], verdict_tally[7],
               verdict_tally[8], verdict_tally[9]);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
